// ===== rtl/crs_pkg.sv =====
// ----------------------------------------------------------------------------
// crs_pkg: shared constants and types of the colour ramp sampler
// Field widths, register codes, reset values and the payload structs that
// travel between the pipeline stages.
// ----------------------------------------------------------------------------
package crs_pkg;

    // Number of colour stops that the register map provides.
    localparam int DEF_MAX_STOPS  = 6;
    localparam int NUM_STOP_REGS  = 6;

    // Field widths.
    localparam int POS_W      = 16;
    localparam int CHAN_W     = 8;
    localparam int NCHAN      = 4;
    localparam int STOP_W     = 48;
    localparam int CNT_W      = 3;
    localparam int REG_IDX_W  = 3;

    // Interpolation fraction: Q1.16 in [0, 1.0], so 17 bits.
    localparam int LT_FRAC    = 16;
    localparam int LT_W       = LT_FRAC + 1;

    // Divider: quotient bits resolved per pipeline stage.
    localparam int DIV_STEPS  = 2;
    localparam int DIV_STAGES = (LT_W + DIV_STEPS - 1) / DIV_STEPS;

    // Blend arithmetic: signed 9 bit difference times signed 18 bit fraction.
    localparam int PROD_W     = 27;
    localparam int SUM_W      = PROD_W - LT_FRAC;

    // Register indexes.
    localparam logic [REG_IDX_W-1:0] REG_STOP_COUNT = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_STOP_FIRST = 3'd1;

    // Reset values.
    localparam logic [CNT_W-1:0] COUNT_RESET = 3'd3;
    localparam logic [STOP_W-1:0] STOP_RESET [NUM_STOP_REGS] = '{
        48'h0000_FFD1_4AFF,
        48'h7333_FF5A_00FF,
        48'hFFFF_1A00_10FF,
        48'h0000_0000_0000,
        48'h0000_0000_0000,
        48'h0000_0000_0000
    };

    // Colour: index 3 is red, 2 green, 1 blue, 0 alpha.
    typedef logic [NCHAN-1:0][CHAN_W-1:0] rgba_t;

    // Operands handed from the select stages to the divider.
    typedef struct packed {
        logic [POS_W-1:0] pos_off;
        logic [POS_W-1:0] span;
        logic             zero;
        logic             ones;
        rgba_t            c0;
        rgba_t            c1;
    } opnd_t;

    // One divider stage.
    typedef struct packed {
        logic [POS_W-1:0] rem;
        logic [LT_W-1:0]  quo;
        logic [POS_W-1:0] span;
        logic             zero;
        logic             ones;
        rgba_t            c0;
        rgba_t            c1;
    } div_t;

    // Operands handed from the divider to the blend stages.
    typedef struct packed {
        logic [LT_W-1:0] lt;
        logic            ones;
        rgba_t           c0;
        rgba_t           c1;
    } blend_t;

    function automatic logic [POS_W-1:0] stop_pos(input logic [STOP_W-1:0] s);
        return s[STOP_W-1:STOP_W-POS_W];
    endfunction

    function automatic rgba_t stop_color(input logic [STOP_W-1:0] s);
        return s[NCHAN*CHAN_W-1:0];
    endfunction

endpackage

// ===== rtl/crs_if.sv =====
// ----------------------------------------------------------------------------
// crs_if: stream interfaces of the colour ramp sampler
// Sample channel carrying the ramp position and colour channel carrying the
// RGBA8 result, both with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface crs_sample_if import crs_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [POS_W-1:0] ramp_pos;

    modport source (output valid, output ramp_pos, input ready);
    modport sink (input valid, input ramp_pos, output ready);
endinterface

interface crs_color_if import crs_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic [CHAN_W-1:0] alpha;

    modport source (output valid, output red, output green, output blue, output alpha,
                    input ready);
    modport sink (input valid, input red, input green, input blue, input alpha,
                  output ready);
endinterface

// ===== rtl/crs_cfg.sv =====
// ----------------------------------------------------------------------------
// crs_cfg: configuration registers
// Holds the stop count and the colour stops, written through a plain
// write port.
// ----------------------------------------------------------------------------
module crs_cfg import crs_pkg::*; #(
    parameter int MAX_STOPS = DEF_MAX_STOPS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              wr_en,
    input  logic [REG_IDX_W-1:0]              wr_index,
    input  logic [STOP_W-1:0]                 wr_data,
    output logic [CNT_W-1:0]                  stop_count,
    output logic [MAX_STOPS-1:0][STOP_W-1:0]  stops
);

    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] count_next;

    // Stop count register.
    always_comb
    begin
        count_next = count_reg;
        if (wr_en && wr_index == REG_STOP_COUNT)
        begin
            count_next = wr_data[CNT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_RESET;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    assign stop_count = count_reg;

    // Stop registers; a write to a stop beyond the stored ones is dropped.
    for (genvar i = 0; i < MAX_STOPS; i++) begin : g_stop
        logic [STOP_W-1:0] stop_reg;
        logic [STOP_W-1:0] stop_next;

        always_comb
        begin
            stop_next = stop_reg;
            if (wr_en && wr_index == REG_STOP_FIRST + REG_IDX_W'(i))
            begin
                stop_next = wr_data;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                stop_reg <= STOP_RESET[i];
            end
            else
            begin
                stop_reg <= stop_next;
            end
        end

        assign stops[i] = stop_reg;
    end

endmodule

// ===== rtl/crs_select.sv =====
// ----------------------------------------------------------------------------
// crs_select: stop search and operand fetch
// First stage compares the position with every stop and picks the bracketing
// pair; second stage fetches that pair and forms distance and span.
// ----------------------------------------------------------------------------
module crs_select import crs_pkg::*; #(
    parameter int MAX_STOPS = DEF_MAX_STOPS
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              en,
    input  logic                              in_valid,
    input  logic [POS_W-1:0]                  ramp_pos,
    input  logic [CNT_W-1:0]                  stop_count,
    input  logic [MAX_STOPS-1:0][STOP_W-1:0]  stops,
    output logic                              out_valid,
    output opnd_t                             out_opnd
);

    localparam int NPAIR  = MAX_STOPS - 1;
    localparam int PAIR_W = (NPAIR > 1) ? $clog2(NPAIR) : 1;
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_STOPS);

    // Kind of result for the selected pair.
    localparam logic [1:0] MODE_ONES   = 2'd0;
    localparam logic [1:0] MODE_LO     = 2'd1;
    localparam logic [1:0] MODE_HI     = 2'd2;
    localparam logic [1:0] MODE_INTERP = 2'd3;

    logic [CNT_W-1:0]     n_cl;
    logic [MAX_STOPS-1:0] le;
    logic [MAX_STOPS-1:0] ge;
    logic                 last_ge;
    logic                 found;
    logic [PAIR_W-1:0]    found_idx;
    logic [CNT_W-1:0]     n_less2;
    logic [1:0]           mode_next;
    logic [PAIR_W-1:0]    pidx_next;

    logic                 v1_reg;
    logic [POS_W-1:0]     t1_reg;
    logic [1:0]           mode1_reg;
    logic [PAIR_W-1:0]    pidx1_reg;

    logic [NPAIR-1:0][2*STOP_W-1:0] pair_vec;
    logic [2*STOP_W-1:0]  pair;
    logic [STOP_W-1:0]    s0;
    logic [STOP_W-1:0]    s1;
    opnd_t                opnd_next;
    logic                 v2_reg;
    opnd_t                opnd_reg;

    // Position compares against every stop, all in parallel.
    always_comb
    begin
        n_cl = (stop_count > MAX_CNT) ? MAX_CNT : stop_count;
        for (int i = 0; i < MAX_STOPS; i++)
        begin
            le[i] = ramp_pos <= stop_pos(stops[i]);
            ge[i] = ramp_pos >= stop_pos(stops[i]);
        end
        last_ge = 1'b0;
        for (int i = 0; i < MAX_STOPS; i++)
        begin
            if (n_cl == CNT_W'(i + 1) && ge[i])
            begin
                last_ge = 1'b1;
            end
        end
    end

    // First bracketing pair wins: scan downwards so the lowest stays.
    always_comb
    begin
        found     = 1'b0;
        found_idx = '0;
        for (int i = NPAIR - 1; i >= 0; i--)
        begin
            if (CNT_W'(i + 1) < n_cl && ge[i] && le[i + 1])
            begin
                found     = 1'b1;
                found_idx = PAIR_W'(i);
            end
        end
    end

    // Result kind and pair index.
    always_comb
    begin
        n_less2   = n_cl - CNT_W'(2);
        mode_next = MODE_HI;
        pidx_next = n_less2[PAIR_W-1:0];
        if (n_cl == '0)
        begin
            mode_next = MODE_ONES;
            pidx_next = '0;
        end
        else if (n_cl == CNT_W'(1) || le[0])
        begin
            mode_next = MODE_LO;
            pidx_next = '0;
        end
        else if (last_ge)
        begin
            mode_next = MODE_HI;
        end
        else if (found)
        begin
            mode_next = MODE_INTERP;
            pidx_next = found_idx;
        end
    end

    // Search stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t1_reg    <= ramp_pos;
            mode1_reg <= mode_next;
            pidx1_reg <= pidx_next;
        end
    end

    // Neighbouring stops side by side so one index fetches a pair.
    for (genvar i = 0; i < NPAIR; i++) begin : g_pair
        assign pair_vec[i] = {stops[i + 1], stops[i]};
    end

    assign pair = pair_vec[pidx1_reg];
    assign s0   = pair[STOP_W-1:0];
    assign s1   = pair[2*STOP_W-1:STOP_W];

    // Operand forming; a single stop colour is sent with a forced zero fraction.
    always_comb
    begin
        opnd_next.pos_off = t1_reg - stop_pos(s0);
        opnd_next.span    = stop_pos(s1) - stop_pos(s0);
        opnd_next.zero    = 1'b1;
        opnd_next.ones    = 1'b0;
        opnd_next.c0      = stop_color(s0);
        opnd_next.c1      = stop_color(s0);
        unique case (mode1_reg)
            MODE_INTERP:
            begin
                opnd_next.zero = stop_pos(s1) == stop_pos(s0);
                opnd_next.c1   = stop_color(s1);
            end
            MODE_LO:
            begin
                opnd_next.c1 = stop_color(s0);
            end
            MODE_HI:
            begin
                opnd_next.c0 = stop_color(s1);
                opnd_next.c1 = stop_color(s1);
            end
            MODE_ONES:
            begin
                opnd_next.ones = 1'b1;
            end
            default:
            begin
                opnd_next.ones = 1'b1;
            end
        endcase
    end

    // Operand stage registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            opnd_reg <= opnd_next;
        end
    end

    assign out_valid = v2_reg;
    assign out_opnd  = opnd_reg;

endmodule

// ===== rtl/crs_div.sv =====
// ----------------------------------------------------------------------------
// crs_div: pipelined restoring divider
// Computes the fraction (offset << 16) / span, two quotient bits per stage.
// The offset never exceeds the span, so the first step starts from the
// offset itself and yields the integer bit of the fraction.
// ----------------------------------------------------------------------------
module crs_div import crs_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  opnd_t  in_opnd,
    output logic   out_valid,
    output blend_t out_blend
);

    logic [DIV_STAGES-1:0] v_reg;
    div_t                  st_reg  [DIV_STAGES];
    div_t                  st_next [DIV_STAGES];
    div_t                  head;
    div_t                  last;

    // Stage zero input.
    always_comb
    begin
        head.rem  = in_opnd.pos_off;
        head.quo  = '0;
        head.span = in_opnd.span;
        head.zero = in_opnd.zero;
        head.ones = in_opnd.ones;
        head.c0   = in_opnd.c0;
        head.c1   = in_opnd.c1;
    end

    for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
        div_t src;

        if (g == 0) begin : g_first
            assign src = head;
        end
        else begin : g_rest
            assign src = st_reg[g - 1];
        end

        // Compare and subtract steps of this stage.
        always_comb
        begin
            div_t         cur;
            logic [POS_W:0] x;
            logic         q;
            cur = src;
            x   = '0;
            q   = 1'b0;
            for (int j = 0; j < DIV_STEPS; j++)
            begin
                if (g * DIV_STEPS + j < LT_W)
                begin
                    if (g * DIV_STEPS + j == 0)
                    begin
                        x = {1'b0, cur.rem};
                    end
                    else
                    begin
                        x = {cur.rem, 1'b0};
                    end
                    q = x >= {1'b0, cur.span};
                    if (q)
                    begin
                        x = x - {1'b0, cur.span};
                    end
                    cur.rem = x[POS_W-1:0];
                    cur.quo = {cur.quo[LT_W-2:0], q};
                end
            end
            st_next[g] = cur;
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                st_reg[g] <= st_next[g];
            end
        end
    end

    // Valid bits travel alongside the stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else if (en)
        begin
            v_reg <= {v_reg[DIV_STAGES-2:0], in_valid};
        end
    end

    // A zero span gives a zero fraction.
    assign last           = st_reg[DIV_STAGES-1];
    assign out_valid      = v_reg[DIV_STAGES-1];
    assign out_blend.lt   = last.zero ? '0 : last.quo;
    assign out_blend.ones = last.ones;
    assign out_blend.c0   = last.c0;
    assign out_blend.c1   = last.c1;

endmodule

// ===== rtl/crs_blend.sv =====
// ----------------------------------------------------------------------------
// crs_blend: channel interpolation
// Multiplies each channel difference by the fraction, then rounds and adds
// the start colour; the ones flag forces every channel to all ones instead.
// ----------------------------------------------------------------------------
module crs_blend import crs_pkg::*; (
    input  logic   clk,
    input  logic   rst_n,
    input  logic   en,
    input  logic   in_valid,
    input  blend_t in_blend,
    output logic   out_valid,
    output rgba_t  out_color
);

    localparam logic signed [PROD_W-1:0] ROUND_HALF = PROD_W'(1 << (LT_FRAC - 1));

    logic signed [PROD_W-1:0] prod_next [NCHAN];
    logic signed [PROD_W-1:0] prod_reg  [NCHAN];
    rgba_t                    c0m_reg;
    logic                     onesm_reg;
    logic                     vm_reg;
    rgba_t                    color_next;
    rgba_t                    color_reg;
    logic                     vr_reg;

    // Signed difference times fraction, one multiplier per channel.
    always_comb
    begin
        logic signed [CHAN_W:0] diff;
        logic signed [LT_W:0]   lts;
        diff = '0;
        lts  = $signed({1'b0, in_blend.lt});
        for (int k = 0; k < NCHAN; k++)
        begin
            diff         = $signed({1'b0, in_blend.c1[k]}) - $signed({1'b0, in_blend.c0[k]});
            prod_next[k] = diff * lts;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg  <= prod_next;
            c0m_reg   <= in_blend.c0;
            onesm_reg <= in_blend.ones;
        end
    end

    // Round to nearest and add the start colour; the floor is the top bits.
    always_comb
    begin
        logic signed [PROD_W-1:0] acc;
        logic [SUM_W-1:0]         v;
        acc = '0;
        v   = '0;
        for (int k = 0; k < NCHAN; k++)
        begin
            acc = prod_reg[k] + ROUND_HALF;
            v   = SUM_W'(c0m_reg[k]) + acc[PROD_W-1:LT_FRAC];
            color_next[k] = onesm_reg ? '1 : v[CHAN_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            color_reg <= color_next;
        end
    end

    // Valid bits of both stages.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vm_reg <= 1'b0;
            vr_reg <= 1'b0;
        end
        else if (en)
        begin
            vm_reg <= in_valid;
            vr_reg <= vm_reg;
        end
    end

    assign out_valid = vr_reg;
    assign out_color = color_reg;

endmodule

// ===== rtl/color_ramp_sampler_unit.sv =====
// Path: an accepted sample passes the search and operand registers, the divider stages,
// the blend product and colour registers and the output register before its colour shows.
// Throughput: one sample per clock; the divider resolves two fraction bits per stage
// over nine stages, and the whole pipeline moves together while the skid slot is free.
// Reset: the stop count returns to 3 and the stops to their default ramp, and all
// pipeline, output and skid valid bits are cleared.
// ----------------------------------------------------------------------------
// color_ramp_sampler_unit: piecewise linear colour ramp sampler
// Interpolates RGBA8 over up to MAX_STOPS configured colour stops for each
// ramp position, with an output register and a skid slot on the colour side.
// ----------------------------------------------------------------------------
module color_ramp_sampler_unit import crs_pkg::*; #(
    parameter int MAX_STOPS = DEF_MAX_STOPS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [STOP_W-1:0]    wr_data,
    crs_sample_if.sink           sample,
    crs_color_if.source          color
);

    logic [CNT_W-1:0]                 stop_count;
    logic [MAX_STOPS-1:0][STOP_W-1:0] stops;
    logic                             adv;
    logic                             opnd_valid;
    opnd_t                            opnd;
    logic                             blend_valid;
    blend_t                           blend;
    logic                             rnd_valid;
    rgba_t                            rnd_color;

    logic  out_valid_reg;
    logic  out_valid_next;
    rgba_t out_color_reg;
    rgba_t out_color_next;
    logic  skid_valid_reg;
    logic  skid_valid_next;
    rgba_t skid_color_reg;
    rgba_t skid_color_next;

    // The pipeline advances whenever the skid slot is empty.
    assign adv          = !skid_valid_reg;
    assign sample.ready = adv;

    crs_cfg #(
        .MAX_STOPS (MAX_STOPS)
    ) u_cfg (
        .clk        (clk),
        .rst_n      (rst_n),
        .wr_en      (wr_en),
        .wr_index   (wr_index),
        .wr_data    (wr_data),
        .stop_count (stop_count),
        .stops      (stops)
    );

    crs_select #(
        .MAX_STOPS (MAX_STOPS)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .en         (adv),
        .in_valid   (sample.valid),
        .ramp_pos   (sample.ramp_pos),
        .stop_count (stop_count),
        .stops      (stops),
        .out_valid  (opnd_valid),
        .out_opnd   (opnd)
    );

    crs_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (opnd_valid),
        .in_opnd   (opnd),
        .out_valid (blend_valid),
        .out_blend (blend)
    );

    crs_blend u_blend (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (adv),
        .in_valid  (blend_valid),
        .in_blend  (blend),
        .out_valid (rnd_valid),
        .out_color (rnd_color)
    );

    // Output register with a skid slot behind it.
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_color_next  = out_color_reg;
        skid_valid_next = skid_valid_reg;
        skid_color_next = skid_color_reg;
        if (skid_valid_reg)
        begin
            if (color.ready)
            begin
                out_valid_next  = 1'b1;
                out_color_next  = skid_color_reg;
                skid_valid_next = 1'b0;
            end
        end
        else if (!out_valid_reg || color.ready)
        begin
            out_valid_next = rnd_valid;
            out_color_next = rnd_color;
        end
        else if (rnd_valid)
        begin
            skid_valid_next = 1'b1;
            skid_color_next = rnd_color;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_color_reg  <= out_color_next;
        skid_color_reg <= skid_color_next;
    end

    assign color.valid = out_valid_reg;
    assign color.red   = out_color_reg[3];
    assign color.green = out_color_reg[2];
    assign color.blue  = out_color_reg[1];
    assign color.alpha = out_color_reg[0];

    // The skid slot is only ever filled behind a waiting output transaction.
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid slot holds a colour while the output register is empty");

    // A finished colour meeting a stalled output must land in the skid slot.
    a_stall_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !color.ready && !skid_valid_reg && rnd_valid |=> skid_valid_reg)
        else $error("finished colour dropped while the output was stalled");

    // Once the output drains, the skid colour moves into the output register in the next cycle.
    a_skid_drain: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg && color.ready |=> !skid_valid_reg && out_valid_reg)
        else $error("skid slot did not drain into the output register");

endmodule

// ===== verif/color_ramp_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_ramp_checker: colour prediction and comparison for the ramp sampler
// Follows the register writes and the sample channel, works out the RGBA8
// colour of every accepted sample, and compares each colour transaction
// field by field with the oldest outstanding prediction.
// ----------------------------------------------------------------------------
module color_ramp_checker import crs_pkg::*; #(
    parameter int MAX_STOPS = DEF_MAX_STOPS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 wr_en,
    input  logic [REG_IDX_W-1:0] wr_index,
    input  logic [STOP_W-1:0]    wr_data,
    crs_sample_if                sample,
    crs_color_if                 color,
    output int                   pending,
    output int                   fails
);

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic [CHAN_W-1:0] alpha;
    } color_t;

    // Local copy of the register file.
    logic [CNT_W-1:0]  ramp_count;
    logic [STOP_W-1:0] ramp_stops [NUM_STOP_REGS];

    color_t expected_colors [$];
    color_t want;
    int     queued     = 0;
    int     fail_count = 0;

    assign pending = queued;
    assign fails   = fail_count;

    function automatic logic [POS_W-1:0] pos_at(input logic [STOP_W-1:0] s);
        return s[STOP_W-1 -: POS_W];
    endfunction

    function automatic color_t rgba_at(input logic [STOP_W-1:0] s);
        return color_t'(s[NCHAN*CHAN_W-1:0]);
    endfunction

    // One channel of the blend: c0 plus the rounded, floored share of c1 - c0.
    function automatic logic [CHAN_W-1:0] mix_chan(input logic [CHAN_W-1:0] c0,
                                                   input logic [CHAN_W-1:0] c1,
                                                   input longint lt);
        longint acc;
        longint v;
        acc = (longint'(c1) - longint'(c0)) * lt + 32768;
        v   = longint'(c0) + (acc >>> LT_FRAC);
        return v[CHAN_W-1:0];
    endfunction

    // Colour of a ramp position under the current stop set.
    function automatic color_t ramp_color(input logic [POS_W-1:0] t);
        int                n;
        logic [POS_W-1:0]  p0;
        logic [POS_W-1:0]  p1;
        longint            lt;
        color_t            c0;
        color_t            c1;
        color_t            mixed;
        n = (ramp_count > MAX_STOPS) ? MAX_STOPS : int'(ramp_count);
        if (n == 0)
            return '1;
        if (t <= pos_at(ramp_stops[0]))
            return rgba_at(ramp_stops[0]);
        if (t >= pos_at(ramp_stops[n-1]))
            return rgba_at(ramp_stops[n-1]);
        for (int i = 0; i + 1 < n; i++)
        begin
            p0 = pos_at(ramp_stops[i]);
            p1 = pos_at(ramp_stops[i+1]);
            if (t >= p0 && t <= p1)
            begin
                lt = 0;
                if (p1 != p0)
                    lt = ((longint'(t) - longint'(p0)) << LT_FRAC)
                         / (longint'(p1) - longint'(p0));
                c0 = rgba_at(ramp_stops[i]);
                c1 = rgba_at(ramp_stops[i+1]);
                mixed.red   = mix_chan(c0.red,   c1.red,   lt);
                mixed.green = mix_chan(c0.green, c1.green, lt);
                mixed.blue  = mix_chan(c0.blue,  c1.blue,  lt);
                mixed.alpha = mix_chan(c0.alpha, c1.alpha, lt);
                return mixed;
            end
        end
        // No pair brackets the position when the stops are out of order.
        return rgba_at(ramp_stops[n-1]);
    endfunction

    task automatic check_chan(input string name, input logic [CHAN_W-1:0] exp_val,
                              input logic [CHAN_W-1:0] got_val);
        if (got_val !== exp_val)
        begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_val, got_val);
            fail_count++;
        end
    endtask

    // Results are compared before new samples are predicted, and predictions use the
    // registers as they stood before any write at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ramp_count = COUNT_RESET;
            for (int i = 0; i < NUM_STOP_REGS; i++)
                ramp_stops[i] = STOP_RESET[i];
            expected_colors.delete();
        end
        else
        begin
            if (color.valid && color.ready)
            begin
                if (expected_colors.size() == 0)
                begin
                    $error("colour transaction with no sample outstanding");
                    fail_count++;
                end
                else
                begin
                    want = expected_colors.pop_front();
                    check_chan("red",   want.red,   color.red);
                    check_chan("green", want.green, color.green);
                    check_chan("blue",  want.blue,  color.blue);
                    check_chan("alpha", want.alpha, color.alpha);
                end
            end
            if (sample.valid && sample.ready)
                expected_colors.insert(expected_colors.size(),
                                       ramp_color(sample.ramp_pos));
            if (wr_en)
            begin
                if (wr_index == REG_STOP_COUNT)
                    ramp_count = wr_data[CNT_W-1:0];
                else if (wr_index >= REG_STOP_FIRST
                         && wr_index < REG_STOP_FIRST + NUM_STOP_REGS)
                    ramp_stops[wr_index - REG_STOP_FIRST] = wr_data;
            end
        end
        queued = expected_colors.size();
    end

endmodule

// ===== verif/color_ramp_sampler_unit_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_ramp_sampler_unit_tb: stimulus and verdict for the colour ramp sampler
// Programs a series of stop sets, from the edge cases to random ramps, and
// streams ramp positions through the block with random gaps on both sides;
// the checker beside the block predicts and compares every colour.
// ----------------------------------------------------------------------------
module color_ramp_sampler_unit_tb import crs_pkg::*; ();

    localparam int CLK_HALF      = 2;
    localparam int RESET_CYCLES  = 6;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int SETTLE_CYCLES = 20;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 50;
    localparam int LONG_HOLD     = 80;

    // Index just past the stop registers; writes to it must be ignored.
    localparam logic [REG_IDX_W-1:0] REG_SPARE = REG_IDX_W'(REG_STOP_FIRST + NUM_STOP_REGS);

    typedef enum int {PLAN_SORTED, PLAN_DUPLICATES, PLAN_UNSORTED, PLAN_CLUSTER} plan_e;

    logic                 clk      = 1'b0;
    logic                 rst_n    = 1'b0;
    logic                 wr_en    = 1'b0;
    logic [REG_IDX_W-1:0] wr_index = '0;
    logic [STOP_W-1:0]    wr_data  = '0;

    int fail_total;
    int pending;
    int rx_hold   = 0;
    bit rx_steady = 1'b0;
    bit tx_steady = 1'b0;

    logic [STOP_W-1:0] stop_plan    [NUM_STOP_REGS];
    logic [POS_W-1:0]  ramp_targets [NUM_STOP_REGS];

    crs_sample_if sample ();
    crs_color_if  color ();

    color_ramp_sampler_unit u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .sample   (sample),
        .color    (color)
    );

    color_ramp_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .sample   (sample),
        .color    (color),
        .pending  (pending),
        .fails    (fail_total)
    );

    initial
    begin
        forever #(CLK_HALF) clk = ~clk;
    end

    // Overall limit on the run.
    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("FAIL color_ramp_sampler_unit");
        $finish;
    end

    // Colour side: random stalls per transaction, plus the occasional long hold.
    initial
    begin
        int gap;
        color.ready = 1'b0;
        @(negedge clk);
        forever
        begin
            if (rx_hold > 0)
            begin
                color.ready <= 1'b0;
                repeat (rx_hold) @(negedge clk);
                rx_hold = 0;
            end
            gap = rx_steady ? 0 : $urandom_range(0, 3);
            if (gap > 0)
            begin
                color.ready <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            color.ready <= 1'b1;
            @(posedge clk);
            while (!color.valid)
                @(posedge clk);
            @(negedge clk);
        end
    end

    // Register write; called at a falling edge, returns at the next one with the
    // enable still high so that writes can follow back to back.
    task automatic put_reg(input logic [REG_IDX_W-1:0] idx, input logic [STOP_W-1:0] val);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
    endtask

    // Offers one ramp position and returns at the falling edge after it is taken.
    task automatic send_pos(input logic [POS_W-1:0] pos);
        int gap;
        gap = tx_steady ? 0 : $urandom_range(0, 3);
        if (gap > 0)
        begin
            sample.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        sample.valid    <= 1'b1;
        sample.ramp_pos <= pos;
        @(posedge clk);
        while (!sample.ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // Drains the block before the registers are touched.
    task automatic drain();
        sample.valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    // Writes the stop count, the whole planned stop set and, on request, the spare index.
    task automatic load_ramp(input logic [CNT_W-1:0] count, input bit with_spare);
        put_reg(REG_STOP_COUNT, STOP_W'(count));
        for (int i = 0; i < NUM_STOP_REGS; i++)
        begin
            put_reg(REG_IDX_W'(REG_STOP_FIRST + i), stop_plan[i]);
            ramp_targets[i] = stop_plan[i][STOP_W-1 -: POS_W];
        end
        if (with_spare)
            put_reg(REG_SPARE, STOP_W'({$urandom(), $urandom()}));
        wr_en <= 1'b0;
    endtask

    // Builds a random stop set of the given shape in stop_plan.
    task automatic make_plan(input plan_e kind);
        logic [POS_W-1:0]  p [NUM_STOP_REGS];
        logic [POS_W-1:0]  tmp;
        logic [POS_W-1:0]  base;
        logic [CHAN_W-1:0] ch;
        base = POS_W'($urandom());
        for (int i = 0; i < NUM_STOP_REGS; i++)
        begin
            p[i] = (kind == PLAN_CLUSTER) ? POS_W'(base + $urandom_range(0, 3))
                                          : POS_W'($urandom());
            if (kind == PLAN_DUPLICATES && i > 0 && $urandom_range(0, 2) == 0)
                p[i] = p[i-1];
        end
        if (kind != PLAN_UNSORTED)
        begin
            for (int i = 0; i < NUM_STOP_REGS - 1; i++)
                for (int j = 0; j < NUM_STOP_REGS - 1 - i; j++)
                    if (p[j] > p[j+1])
                    begin
                        tmp    = p[j];
                        p[j]   = p[j+1];
                        p[j+1] = tmp;
                    end
        end
        if (kind == PLAN_SORTED && $urandom_range(0, 1) == 1)
        begin
            p[0]                 = '0;
            p[NUM_STOP_REGS - 1] = '1;
        end
        // Channels lean towards the extremes now and then.
        for (int i = 0; i < NUM_STOP_REGS; i++)
        begin
            stop_plan[i][STOP_W-1 -: POS_W] = p[i];
            for (int k = 0; k < NCHAN; k++)
            begin
                case ($urandom_range(0, 3))
                    0:       ch = '0;
                    1:       ch = '1;
                    default: ch = CHAN_W'($urandom());
                endcase
                stop_plan[i][k*CHAN_W +: CHAN_W] = ch;
            end
        end
    endtask

    // Random ramp position, often right at or beside a stop.
    function automatic logic [POS_W-1:0] pick_pos();
        int kind;
        kind = $urandom_range(0, 9);
        if (kind < 4)
            return POS_W'($urandom());
        else if (kind < 8)
            return POS_W'(ramp_targets[$urandom_range(0, NUM_STOP_REGS - 1)]
                          + $urandom_range(0, 4) - 2);
        else if (kind == 8)
            return '0;
        else
            return '1;
    endfunction

    // Main sequence.
    initial
    begin
        logic [CNT_W-1:0] count;
        sample.valid    = 1'b0;
        sample.ramp_pos = '0;
        repeat (RESET_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Default ramp after reset: the ends, the middle stop and its neighbours.
        send_pos(16'h0000);
        send_pos(16'h0001);
        send_pos(16'h3999);
        send_pos(16'h7332);
        send_pos(16'h7333);
        send_pos(16'h7334);
        send_pos(16'hFFFF);

        // No stops in use: plain white.
        drain();
        put_reg(REG_STOP_COUNT, STOP_W'(0));
        wr_en <= 1'b0;
        send_pos(16'h8000);
        send_pos(16'hFFFF);

        // A single stop colours the whole ramp.
        drain();
        put_reg(REG_STOP_COUNT, STOP_W'(1));
        put_reg(REG_STOP_FIRST, 48'h4000_00FF_00FF);
        wr_en <= 1'b0;
        send_pos(16'h0000);
        send_pos(16'h4000);
        send_pos(16'hFFFF);

        // Count above the limit, a zero-span pair, and a write to the spare index.
        drain();
        stop_plan[0] = 48'h0000_0000_0000;
        stop_plan[1] = 48'h2000_FFFF_FFFF;
        stop_plan[2] = 48'h2000_8080_8080;
        stop_plan[3] = 48'h6000_00FF_00FF;
        stop_plan[4] = 48'hA000_FF00_FF00;
        stop_plan[5] = 48'hFFFF_1234_5678;
        load_ramp(3'd7, 1'b1);
        send_pos(16'h1000);
        send_pos(16'h2000);
        send_pos(16'h4000);
        send_pos(16'h8000);
        send_pos(16'hC000);
        send_pos(16'hFFFE);
        send_pos(16'hFFFF);

        // Stops out of order.
        drain();
        stop_plan[0] = 48'h8000_FF00_0000;
        stop_plan[1] = 48'h2000_00FF_0000;
        stop_plan[2] = 48'hE000_0000_FF00;
        stop_plan[3] = 48'h4000_0000_00FF;
        load_ramp(3'd4, 1'b0);
        send_pos(16'h1000);
        send_pos(16'h3000);
        send_pos(16'h9000);

        // Random stop sets with random positions.
        for (int ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            tx_steady = (ph % 4 == 1);
            rx_steady = (ph % 4 == 1) || (ph % 4 == 2);
            case (ph)
                0:
                begin
                    for (int i = 0; i < NUM_STOP_REGS; i++)
                        stop_plan[i] = '1;
                    count = 3'd6;
                end
                1:
                begin
                    for (int i = 0; i < NUM_STOP_REGS; i++)
                        stop_plan[i] = '0;
                    count = 3'd2;
                end
                2:
                begin
                    make_plan(PLAN_SORTED);
                    count = 3'd7;
                end
                default:
                begin
                    make_plan(plan_e'($urandom_range(0, 3)));
                    count = ($urandom_range(0, 3) == 0) ? CNT_W'($urandom_range(0, 7))
                                                        : CNT_W'($urandom_range(2, 6));
                end
            endcase
            load_ramp(count, ph % 3 == 0);
            for (int it = 0; it < PHASE_ITEMS; it++)
            begin
                // Long hold on the colour side so that the pipeline backs up.
                if (ph == 4 && it == 10)
                    rx_hold = LONG_HOLD;
                // Sender waits for the block to empty in the middle of a phase.
                if (ph == 6 && it == 25)
                begin
                    sample.valid <= 1'b0;
                    wait (pending == 0);
                    @(negedge clk);
                end
                send_pos(pick_pos());
            end
        end

        sample.valid <= 1'b0;
        wait (pending == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (fail_total == 0)
            $display("PASS color_ramp_sampler_unit");
        else
            $display("FAIL color_ramp_sampler_unit");
        $finish;
    end

endmodule

// ===== color_ramp_sampler_unit.f =====
rtl/crs_pkg.sv
rtl/crs_if.sv
rtl/crs_cfg.sv
rtl/crs_select.sv
rtl/crs_div.sv
rtl/crs_blend.sv
rtl/color_ramp_sampler_unit.sv
verif/color_ramp_checker.sv
verif/color_ramp_sampler_unit_tb.sv
